FILE: src/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types, character codes and echo tables for the console line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

  // default line store depth
  localparam int unsigned LINE_BYTES_DEF = 16;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_END  = 2'd2
  } cle_kind_t;

  // received control codes
  localparam logic [7:0] CTL_C   = 8'h03;
  localparam logic [7:0] CTL_H   = 8'h08;
  localparam logic [7:0] CTL_DEL = 8'h7F;
  localparam logic [7:0] CTL_U   = 8'h15;
  localparam logic [7:0] CTL_W   = 8'h17;
  localparam logic [7:0] CTL_R   = 8'h12;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_LF  = 8'h0A;

  // printable range bounds
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h80;

  // echoed characters
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UC_C   = 8'h43;
  localparam logic [7:0] CH_UC_R   = 8'h52;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_UC_K   = 8'h4B;

  // stored characters at or below this count as blanks for word erase
  localparam logic [6:0] BLANK_MAX = 7'h20;

  // received byte classes
  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_PRINT,
    CLS_INTR,
    CLS_ERASE,
    CLS_KILL,
    CLS_WORD,
    CLS_REPRINT,
    CLS_ENTER
  } cle_cls_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEQ,
    S_WFETCH,
    S_WWAIT,
    S_LREAD,
    S_LEMIT,
    S_END
  } cle_state_t;

  // line store read address select
  typedef enum logic [1:0] {
    RD_NONE,
    RD_TAIL,
    RD_PREV,
    RD_IDX
  } cle_rd_sel_t;

  // result data select
  typedef enum logic [2:0] {
    OSEL_SEQ,
    OSEL_BYTE,
    OSEL_BEL,
    OSEL_MEM,
    OSEL_ZERO
  } cle_out_sel_t;

  // controller to datapath
  typedef struct packed {
    logic         take;
    cle_rd_sel_t  rd_sel;
    logic         cur_load;
    logic         store_wr;
    logic         len_clr;
    logic         len_dec;
    logic         pos_clr;
    logic         pos_inc;
    logic         idx_clr;
    logic         idx_inc;
    logic         out_load;
    cle_out_sel_t out_sel;
    cle_kind_t    out_kind;
    logic         out_last;
  } cle_cmd_t;

  // datapath to controller
  typedef struct packed {
    cle_cls_t cls;
    logic     in_valid;
    logic     len_zero;
    logic     len_one;
    logic     full;
    logic     pos_end;
    logic     idx_end;
    logic     next_blank;
    logic     cur_blank;
    logic     out_free;
  } cle_sts_t;

  // sort a received byte into its class
  function automatic cle_cls_t classify(input logic [7:0] c);
    cle_cls_t r;
    case (c)
      CTL_C:          r = CLS_INTR;
      CTL_H, CTL_DEL: r = CLS_ERASE;
      CTL_U:          r = CLS_KILL;
      CTL_W:          r = CLS_WORD;
      CTL_R:          r = CLS_REPRINT;
      CTL_CR, CTL_LF: r = CLS_ENTER;
      default: begin
        if (c >= PRINT_LO && c < PRINT_HI) r = CLS_PRINT;
        else r = CLS_OTHER;
      end
    endcase
    return r;
  endfunction

  // position of the final byte of each fixed echo sequence
  function automatic logic [2:0] seq_last_pos(input cle_cls_t cls);
    logic [2:0] r;
    case (cls)
      CLS_INTR:    r = 3'd3;
      CLS_REPRINT: r = 3'd3;
      CLS_KILL:    r = 3'd4;
      CLS_ENTER:   r = 3'd1;
      default:     r = 3'd2;
    endcase
    return r;
  endfunction

  // fixed echo sequence contents
  function automatic logic [7:0] seq_byte(input cle_cls_t cls, input logic [2:0] pos);
    logic [7:0] r;
    case (cls)
      CLS_INTR, CLS_REPRINT: begin
        case (pos)
          3'd0:    r = CH_CARET;
          3'd1:    r = (cls == CLS_INTR) ? CH_UC_C : CH_UC_R;
          3'd2:    r = CH_CR;
          default: r = CH_LF;
        endcase
      end
      CLS_KILL: begin
        case (pos)
          3'd0:    r = CH_CR;
          3'd1:    r = CH_ESC;
          3'd2:    r = CH_LBRACK;
          3'd3:    r = CH_TWO;
          default: r = CH_UC_K;
        endcase
      end
      CLS_ENTER: begin
        r = (pos == 3'd0) ? CH_CR : CH_LF;
      end
      default: begin
        r = (pos == 3'd1) ? CH_SP : CH_BS;
      end
    endcase
    return r;
  endfunction

endpackage

FILE: src/cle_in_if.sv
// ----------------------------------------------------------------------------
// cle_in_if
// Received byte channel: valid/ready handshake with one raw console byte.
// ----------------------------------------------------------------------------
interface cle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

FILE: src/cle_out_if.sv
// ----------------------------------------------------------------------------
// cle_out_if
// Result channel: valid/ready handshake with kind, data and last marker.
// ----------------------------------------------------------------------------
interface cle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data;
  logic       last;

  modport source (output valid, output kind, output data, output last, input ready);
  modport sink   (input valid, input kind, input data, input last, output ready);
endinterface

FILE: src/cle_datapath.sv
// ----------------------------------------------------------------------------
// cle_datapath
// Line store, length and sequence counters, byte latch and result register.
// ----------------------------------------------------------------------------
module cle_datapath
  import cle_pkg::*;
#(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  cle_in_if.sink        byte_ch,
  cle_out_if.source     result_ch,
  input  cle_cmd_t      cmd,
  output cle_sts_t      sts
);

  localparam int unsigned LEN_W = $clog2(LINE_BYTES);

  logic [6:0]       mem [LINE_BYTES];
  logic [6:0]       rdata;
  logic [LEN_W-1:0] raddr;
  logic             rd_en;

  logic [7:0]       cur_byte;
  cle_cls_t         cls;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] idx;
  logic [2:0]       pos;
  logic             cur_blank;

  logic             ovalid;
  logic [1:0]       okind;
  logic [7:0]       odata;
  logic             olast;
  logic [7:0]       odata_next;

  // input handshake and byte latch
  assign byte_ch.ready = cmd.take;

  always_ff @(posedge clk) begin
    if (byte_ch.valid && cmd.take) begin
      cur_byte <= byte_ch.byte_in;
    end
  end

  assign cls = classify(cur_byte);

  // line length
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cmd.len_clr) begin
      len <= '0;
    end else if (cmd.len_dec) begin
      len <= len - LEN_W'(1);
    end else if (cmd.store_wr) begin
      len <= len + LEN_W'(1);
    end
  end

  // echo sequence position and line read index
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      idx <= '0;
    end else begin
      if (cmd.pos_clr) begin
        pos <= '0;
      end else if (cmd.pos_inc) begin
        pos <= pos + 3'd1;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + LEN_W'(1);
      end
    end
  end

  // read address select
  always_comb begin
    rd_en = 1'b1;
    case (cmd.rd_sel)
      RD_TAIL: raddr = len - LEN_W'(1);
      RD_PREV: raddr = len - LEN_W'(2);
      RD_IDX:  raddr = idx;
      default: begin
        raddr = idx;
        rd_en = 1'b0;
      end
    endcase
  end

  // line store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      mem[len] <= cur_byte[6:0];
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // blank flag of the character being erased
  always_ff @(posedge clk) begin
    if (cmd.cur_load) begin
      cur_blank <= (rdata <= BLANK_MAX);
    end
  end

  // result data select
  always_comb begin
    case (cmd.out_sel)
      OSEL_SEQ:  odata_next = seq_byte(cls, pos);
      OSEL_BYTE: odata_next = cur_byte;
      OSEL_BEL:  odata_next = CH_BEL;
      OSEL_MEM:  odata_next = {1'b0, rdata};
      default:   odata_next = 8'h00;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (cmd.out_load) begin
      ovalid <= 1'b1;
    end else if (result_ch.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      okind <= cmd.out_kind;
      odata <= odata_next;
      olast <= cmd.out_last;
    end
  end

  assign result_ch.valid = ovalid;
  assign result_ch.kind  = okind;
  assign result_ch.data  = odata;
  assign result_ch.last  = olast;

  // status back to the controller
  always_comb begin
    sts.cls        = cls;
    sts.in_valid   = byte_ch.valid;
    sts.len_zero   = (len == '0);
    sts.len_one    = (len == LEN_W'(1));
    sts.full       = (len == LEN_W'(LINE_BYTES - 1));
    sts.pos_end    = (pos == seq_last_pos(cls));
    sts.idx_end    = (idx == len - LEN_W'(1));
    sts.next_blank = (rdata <= BLANK_MAX);
    sts.cur_blank  = cur_blank;
    sts.out_free   = !ovalid || result_ch.ready;
  end

`ifndef SYNTH
  // length never passes the usable store size
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(LINE_BYTES - 1))
    else $error("line length beyond store size");

  // no character dropped from an empty line
  a_dec_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.len_dec |-> (len != '0))
    else $error("erase on empty line");

  // a stored character grows the line by one
  a_store_grow: assert property (@(posedge clk) disable iff (rst)
    (cmd.store_wr && !cmd.len_clr && !cmd.len_dec) |=> (len == $past(len) + LEN_W'(1)))
    else $error("store write without length step");
`endif

endmodule

FILE: src/cle_ctrl.sv
// ----------------------------------------------------------------------------
// cle_ctrl
// Sequencer for the line editor: decodes the latched byte and steps the
// datapath through echo sequences, word erase and line read-out.
// ----------------------------------------------------------------------------
module cle_ctrl
  import cle_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cle_sts_t sts,
  output cle_cmd_t cmd
);

  cle_state_t state;
  cle_state_t state_next;
  logic       word_stop;
  logic       seq_done;

  // word erase ends after this character when the line empties or a word
  // character is followed by a blank
  assign word_stop = sts.len_one || (!sts.cur_blank && sts.next_blank);

  // whether the fixed sequence is the final output of this byte
  always_comb begin
    case (sts.cls)
      CLS_WORD:    seq_done = word_stop;
      CLS_REPRINT: seq_done = sts.len_zero;
      CLS_ENTER:   seq_done = 1'b0;
      default:     seq_done = 1'b1;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (sts.in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (sts.cls)
          CLS_PRINT: begin
            if (sts.out_free) state_next = S_IDLE;
          end
          CLS_ERASE: state_next = sts.len_zero ? S_IDLE : S_SEQ;
          CLS_WORD:  state_next = sts.len_zero ? S_IDLE : S_WFETCH;
          CLS_OTHER: state_next = S_IDLE;
          default:   state_next = S_SEQ;
        endcase
      end
      S_WFETCH: state_next = S_WWAIT;
      S_WWAIT:  state_next = S_SEQ;
      S_SEQ: begin
        if (sts.out_free && sts.pos_end) begin
          case (sts.cls)
            CLS_WORD:    state_next = word_stop ? S_IDLE : S_SEQ;
            CLS_REPRINT: state_next = sts.len_zero ? S_IDLE : S_LREAD;
            CLS_ENTER:   state_next = sts.len_zero ? S_END : S_LREAD;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_LREAD: state_next = S_LEMIT;
      S_LEMIT: begin
        if (sts.out_free) begin
          if (!sts.idx_end) state_next = S_LREAD;
          else if (sts.cls == CLS_ENTER) state_next = S_END;
          else state_next = S_IDLE;
        end
      end
      S_END: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = RD_NONE;
    cmd.out_sel  = OSEL_SEQ;
    cmd.out_kind = KIND_ECHO;
    case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
      end
      S_DECODE: begin
        cmd.pos_clr = 1'b1;
        if (sts.cls == CLS_PRINT && sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          cmd.out_sel  = sts.full ? OSEL_BEL : OSEL_BYTE;
          cmd.store_wr = !sts.full;
        end
      end
      S_WFETCH: begin
        cmd.rd_sel = RD_TAIL;
      end
      S_WWAIT: begin
        cmd.cur_load = 1'b1;
        cmd.pos_clr  = 1'b1;
      end
      S_SEQ: begin
        // keep the character before the tail on hand for the stop check
        if (sts.cls == CLS_WORD) cmd.rd_sel = RD_PREV;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = sts.pos_end && seq_done;
          if (!sts.pos_end) begin
            cmd.pos_inc = 1'b1;
          end else begin
            cmd.pos_clr = 1'b1;
            cmd.idx_clr = 1'b1;
            case (sts.cls)
              CLS_INTR, CLS_KILL: cmd.len_clr = 1'b1;
              CLS_ERASE:          cmd.len_dec = 1'b1;
              CLS_WORD: begin
                cmd.len_dec  = 1'b1;
                cmd.cur_load = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
      S_LREAD: begin
        cmd.rd_sel = RD_IDX;
      end
      S_LEMIT: begin
        cmd.out_sel  = OSEL_MEM;
        cmd.out_kind = (sts.cls == CLS_ENTER) ? KIND_LINE : KIND_ECHO;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = sts.idx_end && (sts.cls != CLS_ENTER);
          cmd.idx_inc  = 1'b1;
        end
      end
      S_END: begin
        cmd.out_sel  = OSEL_ZERO;
        cmd.out_kind = KIND_END;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          cmd.len_clr  = 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // results are only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending result");

  // a full line never takes another character
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    cmd.store_wr |-> !sts.full)
    else $error("store write on full line");

  // the final result of a byte returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.out_last) |=> (state == S_IDLE))
    else $error("sequencer busy after final result");

  // a new byte is only taken when idle
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> (state == S_IDLE))
    else $error("byte taken while busy");
`endif

endmodule

FILE: src/console_line_editor_unit.sv
// ----------------------------------------------------------------------------
// console_line_editor_unit
// Canonical-mode line editor: takes console bytes, keeps the current line,
// and produces terminal echo, completed line bytes and end-of-line markers.
//
//   channel    dir  signals                    payload
//   byte_ch    in   valid ready byte_in        raw received byte
//   result_ch  out  valid ready kind data last echo, line byte or end marker
//
// One byte is processed at a time; a new byte is taken once the final
// result of the previous one sits in the output register.
// Steps per byte: the byte is taken in the idle state and then decoded;
// then each fixed echo byte or end marker is emitted, each stored byte
// read back from the line store is read and then emitted, and a word
// erase first fetches the tail character from the line store. The longest
// byte to handle is a word erase over a full line.
// Reset clears the length and sequencer; the line store is not cleared.
// A stalled result channel holds the sequencer in place, one result pending.
// ----------------------------------------------------------------------------
module console_line_editor_unit
  import cle_pkg::*;
#(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  cle_in_if.sink    byte_ch,
  cle_out_if.source result_ch
);

  cle_cmd_t cmd;
  cle_sts_t sts;

  // sequencer
  cle_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // line store and result path
  cle_datapath #(
    .LINE_BYTES (LINE_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: tb/sv/cle_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cle_checker
// Watches both channels of the line editor, keeps its own copy of the line
// and length, predicts every echo, line byte and end marker, and compares
// each result transfer with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module cle_checker
  import cle_pkg::*;
#(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic       byte_ready,
  input  logic [7:0] byte_in,
  input  logic       result_valid,
  input  logic       result_ready,
  input  logic [1:0] kind,
  input  logic [7:0] data,
  input  logic       last,
  output int         pending,
  output int         failures
);

  typedef struct {
    cle_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } editor_result_t;

  // mirrored line state
  logic [6:0]  line_buf [LINE_BYTES];
  int unsigned line_len;

  editor_result_t key_results[$];
  editor_result_t awaited_results[$];

  function automatic void emit(input cle_kind_t k, input logic [7:0] d);
    editor_result_t r;
    r.kind = k;
    r.data = d;
    r.last = 1'b0;
    key_results.push_back(r);
  endfunction

  // backspace, space, backspace over the final stored character
  function automatic void rub_out();
    emit(KIND_ECHO, CH_BS);
    emit(KIND_ECHO, CH_SP);
    emit(KIND_ECHO, CH_BS);
    line_len--;
  endfunction

  // results caused by one received byte, in order
  function automatic void predict_editor(input logic [7:0] c);
    int unsigned i;
    key_results.delete();
    case (c)
      CTL_C: begin
        emit(KIND_ECHO, CH_CARET);
        emit(KIND_ECHO, CH_UC_C);
        emit(KIND_ECHO, CH_CR);
        emit(KIND_ECHO, CH_LF);
        line_len = 0;
      end
      CTL_H, CTL_DEL: begin
        if (line_len > 0) rub_out();
      end
      CTL_U: begin
        emit(KIND_ECHO, CH_CR);
        emit(KIND_ECHO, CH_ESC);
        emit(KIND_ECHO, CH_LBRACK);
        emit(KIND_ECHO, CH_TWO);
        emit(KIND_ECHO, CH_UC_K);
        line_len = 0;
      end
      CTL_W: begin
        // trailing blanks first, then the word in front of them
        while (line_len > 0 && line_buf[line_len - 1] <= BLANK_MAX) rub_out();
        while (line_len > 0 && line_buf[line_len - 1] > BLANK_MAX) rub_out();
      end
      CTL_R: begin
        emit(KIND_ECHO, CH_CARET);
        emit(KIND_ECHO, CH_UC_R);
        emit(KIND_ECHO, CH_CR);
        emit(KIND_ECHO, CH_LF);
        for (i = 0; i < line_len; i++) emit(KIND_ECHO, {1'b0, line_buf[i]});
      end
      CTL_CR, CTL_LF: begin
        emit(KIND_ECHO, CH_CR);
        emit(KIND_ECHO, CH_LF);
        for (i = 0; i < line_len; i++) emit(KIND_LINE, {1'b0, line_buf[i]});
        emit(KIND_END, 8'h00);
        line_len = 0;
      end
      default: begin
        // printable: store and echo, or ring the bell once the line is full
        if (c >= PRINT_LO && c < PRINT_HI) begin
          if (line_len >= LINE_BYTES - 1) begin
            emit(KIND_ECHO, CH_BEL);
          end else begin
            line_buf[line_len] = c[6:0];
            line_len++;
            emit(KIND_ECHO, c);
          end
        end
      end
    endcase
    if (key_results.size() > 0) key_results[key_results.size() - 1].last = 1'b1;
  endfunction

  function automatic void note_failure(input string msg);
    if (failures < 10) $display("%0t: %s", $realtime, msg);
    failures++;
  endfunction

  always @(posedge clk) begin
    editor_result_t want;
    if (rst) begin
      line_len = 0;
      awaited_results.delete();
      failures = 0;
      pending <= 0;
    end else begin
      // result transfer: compare with the oldest prediction
      if (result_valid && result_ready) begin
        if (awaited_results.size() == 0) begin
          note_failure($sformatf("unexpected result: kind %0d data %02h last %0b",
                                 kind, data, last));
        end else begin
          want = awaited_results.pop_front();
          if (kind !== 2'(want.kind) || data !== want.data || last !== want.last)
            note_failure($sformatf({"result mismatch: expected kind %0d data %02h ",
                                    "last %0b, got kind %0d data %02h last %0b"},
                                   want.kind, want.data, want.last, kind, data, last));
        end
      end
      // byte transfer: queue what it should cause
      if (byte_valid && byte_ready) begin
        predict_editor(byte_in);
        foreach (key_results[j]) awaited_results.push_back(key_results[j]);
      end
      pending <= awaited_results.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives console bytes into the line editor and stalls its result channel at
// random; a directed opening covers empty-line edits, blanks and word erase,
// line kill, interrupt and ignored bytes, then random typing with bursts that
// fill the line. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import cle_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned KEY_TARGET   = 200;
  localparam int unsigned DRAIN_CYCLES = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  bit          steady = 1'b0;
  int unsigned phase_left = 0;
  int unsigned cycles = 0;
  int          pending;
  int          failures;

  cle_in_if  byte_ch ();
  cle_out_if result_ch ();

  console_line_editor_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch)
  );

  cle_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_ch.valid),
    .byte_ready   (byte_ch.ready),
    .byte_in      (byte_ch.byte_in),
    .result_valid (result_ch.valid),
    .result_ready (result_ch.ready),
    .kind         (result_ch.kind),
    .data         (result_ch.data),
    .last         (result_ch.last),
    .pending      (pending),
    .failures     (failures)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("console_line_editor_unit verification failed");
      $finish;
    end
  end

  // idle cycles before the next transfer; none during a steady stretch
  function automatic int unsigned idle_draw();
    return steady ? 0 : $urandom_range(0, 14);
  endfunction

  // one byte transfer, with an idle gap in front of it
  task automatic send_key(input logic [7:0] b);
    int unsigned gap;
    if (phase_left == 0) begin
      steady = ($urandom_range(0, 3) == 0);
      phase_left = $urandom_range(20, 60);
    end
    phase_left--;
    gap = idle_draw();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.byte_in <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
  endtask

  // result side stalls
  initial begin
    int unsigned stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    logic [7:0]  opening_keys [$] = '{
      CTL_H, CTL_DEL, CTL_W, CTL_R, CTL_CR, CTL_LF,
      CH_SP, 8'h61, 8'h7E, CH_SP, CH_SP, CTL_W, CTL_R, CTL_DEL,
      8'h78, 8'h79, CTL_U, 8'h7A, CTL_C, 8'h00, 8'hFF, 8'h80, 8'h1F, 8'h71, CTL_LF
    };
    logic [7:0]  key;
    bit          counted;
    int unsigned n_keys;
    int unsigned run;
    int unsigned pick;
    byte_ch.valid   <= 1'b0;
    byte_ch.byte_in <= 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_keys[i]) send_key(opening_keys[i]);

    n_keys = 0;
    while (n_keys < KEY_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        // typing burst, long enough to fill the line now and then
        run = $urandom_range(10, 20);
        repeat (run) begin
          key = ($urandom_range(0, 7) == 0) ? CH_SP : 8'($urandom_range(8'h21, 8'h7E));
          send_key(key);
          n_keys++;
        end
      end else begin
        pick = $urandom_range(0, 99);
        counted = 1'b1;
        if (pick < 50)
          key = ($urandom_range(0, 3) == 0) ? CH_SP : 8'($urandom_range(8'h21, 8'h7E));
        else if (pick < 58) key = $urandom_range(0, 1) ? CTL_CR : CTL_LF;
        else if (pick < 66) key = $urandom_range(0, 1) ? CTL_H : CTL_DEL;
        else if (pick < 72) key = CTL_W;
        else if (pick < 76) key = CTL_U;
        else if (pick < 79) key = CTL_C;
        else if (pick < 84) key = CTL_R;
        else begin
          // bytes the editor drops: high half or unlisted control codes
          counted = 1'b0;
          if ($urandom_range(0, 1)) begin
            key = 8'($urandom_range(8'h80, 8'hFF));
          end else begin
            do key = 8'($urandom_range(0, 31));
            while (key inside {CTL_C, CTL_H, CTL_U, CTL_W, CTL_R, CTL_CR, CTL_LF});
          end
        end
        send_key(key);
        if (counted) n_keys++;
      end
    end
    byte_ch.valid <= 1'b0;

    // drain the remaining results, then let the block settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("console_line_editor_unit verification clean");
    end else begin
      $display("console_line_editor_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: console_line_editor_unit.f
src/cle_pkg.sv
src/cle_in_if.sv
src/cle_out_if.sv
src/cle_datapath.sv
src/cle_ctrl.sv
src/console_line_editor_unit.sv
tb/sv/cle_checker.sv
tb/sv/testbench.sv
